// ===== rtl/ffpa_pkg.sv =====
`default_nettype none
package ffpa_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int POOL_BYTES_MAX = 65536;

    localparam int SIZE_W = 17;
    localparam int OFFS_W = 16;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0] POOL_LIM =
        (POOL_BYTES_MAX > 131071) ? SIZE_MAX : SIZE_W'(POOL_BYTES_MAX);
    localparam logic [SIZE_W-1:0] POOL_RST =
        (POOL_BYTES_MAX < 65536) ? SIZE_W'(POOL_BYTES_MAX) : SIZE_W'(65536);

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_POOL_FULL  = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [OFFS_W-1:0] offset;
        logic [SIZE_W-1:0] size;
        logic              busy;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    function automatic logic [SIZE_W-1:0] sub_sat(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [SIZE_W-1:0] add_sat(input logic [SIZE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
        logic [SIZE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_W] ? SIZE_MAX : s[SIZE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/first_fit_pool_allocator.sv =====
`default_nettype none
// First-fit pool allocator. A request beat is taken when start is high and
// busy is low; action selects allocate, release or clear. Each request gives
// exactly one result beat, shown for one cycle while o_done is high.
// Allocate and release walk the record memory from the first record, one
// record per cycle, and stop at the first match. The block stays busy from
// the accepting edge until the match is found, or until every record has
// been read when nothing matches; the result beat follows in the cycle
// busy falls, and a new request may be taken in that same cycle. Clear and
// the undefined action never raise busy; their result beat shows in the
// cycle after the one that takes them. The record memory read port sets the
// scan rate. The pool size register is written through i_cfg_we and
// i_cfg_data, by the user only while the block is idle, which the block
// does not enforce; it applies at once to new bump allocations.
// Reset empties the record table, zeroes the bump offset and loads the free
// count from the pool size; the record memory itself needs no clearing since
// only records below the record count are read. The receiver cannot stall.
module first_fit_pool_allocator #(
    parameter int MAX_RECORDS = ffpa_pkg::MAX_RECORDS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [ffpa_pkg::SIZE_W-1:0] i_cfg_data,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_action,
    input  wire logic [ffpa_pkg::SIZE_W-1:0] i_request_size,
    input  wire logic [ffpa_pkg::OFFS_W-1:0] i_release_offset,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [ffpa_pkg::OFFS_W-1:0]     o_block_offset,
    output logic                            o_reused,
    output logic [ffpa_pkg::SIZE_W-1:0]     o_free_bytes
);

    import ffpa_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    t_state             r_state, n_state;
    t_action            r_action, n_action;
    logic [SIZE_W-1:0]  r_req, n_req;
    logic [OFFS_W-1:0]  r_roff, n_roff;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    logic [AW-1:0]      r_chk_idx, n_chk_idx;
    logic               r_chk_vld, n_chk_vld;
    logic [CW-1:0]      r_count, n_count;
    logic [SIZE_W-1:0]  r_bump, n_bump;
    logic [SIZE_W-1:0]  r_free, n_free;
    logic [SIZE_W-1:0]  r_pool;
    logic               r_out_vld, n_out_vld;
    t_status            r_status, n_status;
    logic [OFFS_W-1:0]  r_offset, n_offset;
    logic               r_reused, n_reused;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_rec               ram_wdata;
    logic               ram_re;
    logic [REC_W-1:0]   ram_rdata;
    t_rec               rec;
    logic               hit;
    logic [SIZE_W-1:0]  room;

    ffpa_ram #(
        .WIDTH(REC_W),
        .DEPTH(MAX_RECORDS)
    ) u_rec_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_rd_idx[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign rec  = t_rec'(ram_rdata);
    assign hit  = (r_action == ACT_ALLOC) ? (!rec.busy && rec.size >= r_req)
                                          : (rec.busy && rec.offset == r_roff);
    assign room = sub_sat(r_pool, r_bump);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_bump    <= '0;
            r_free    <= POOL_RST;
            r_pool    <= POOL_RST;
            r_out_vld <= 1'b0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_bump    <= n_bump;
            r_free    <= n_free;
            r_out_vld <= n_out_vld;
            r_chk_vld <= n_chk_vld;
            if (i_cfg_we) begin
                r_pool <= (i_cfg_data > POOL_LIM) ? POOL_LIM : i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_req     <= n_req;
        r_roff    <= n_roff;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_status  <= n_status;
        r_offset  <= n_offset;
        r_reused  <= n_reused;
    end

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_req     = r_req;
        n_roff    = r_roff;
        n_rd_idx  = r_rd_idx;
        n_chk_idx = r_chk_idx;
        n_chk_vld = r_chk_vld;
        n_count   = r_count;
        n_bump    = r_bump;
        n_free    = r_free;
        n_out_vld = 1'b0;
        n_status  = r_status;
        n_offset  = r_offset;
        n_reused  = r_reused;
        ram_we    = 1'b0;
        ram_waddr = r_chk_idx;
        ram_wdata = rec;
        ram_re    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action  = t_action'(i_action);
                    n_req     = i_request_size;
                    n_roff    = i_release_offset;
                    n_rd_idx  = '0;
                    n_chk_vld = 1'b0;
                    n_status  = ST_DONE;
                    n_offset  = '0;
                    n_reused  = 1'b0;
                    unique case (t_action'(i_action))
                        ACT_ALLOC, ACT_RELEASE: begin
                            n_state = S_SCAN;
                        end
                        ACT_CLEAR: begin
                            n_count   = '0;
                            n_bump    = '0;
                            n_free    = r_pool;
                            n_out_vld = 1'b1;
                        end
                        ACT_NONE: begin
                            n_out_vld = 1'b1;
                        end
                        default: begin
                            n_out_vld = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_chk_vld && hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk_idx;
                    ram_wdata = rec;
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_chk_vld = 1'b0;
                    if (r_action == ACT_ALLOC) begin
                        ram_wdata.busy = 1'b1;
                        n_free         = sub_sat(r_free, rec.size);
                        n_offset       = rec.offset;
                        n_reused       = 1'b1;
                    end else begin
                        ram_wdata.busy = 1'b0;
                        n_free         = add_sat(r_free, rec.size);
                    end
                end else if (r_rd_idx < r_count) begin
                    ram_re    = 1'b1;
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_chk_idx = r_rd_idx[AW-1:0];
                    n_chk_vld = 1'b1;
                end else begin
                    n_state   = S_IDLE;
                    n_out_vld = 1'b1;
                    n_chk_vld = 1'b0;
                    if (r_action == ACT_ALLOC) begin
                        if (r_req > room || r_bump[SIZE_W-1]) begin
                            n_status = ST_POOL_FULL;
                        end else if (r_count == CW'(MAX_RECORDS)) begin
                            n_status = ST_TABLE_FULL;
                        end else begin
                            ram_we           = 1'b1;
                            ram_waddr        = r_count[AW-1:0];
                            ram_wdata.offset = r_bump[OFFS_W-1:0];
                            ram_wdata.size   = r_req;
                            ram_wdata.busy   = 1'b1;
                            n_count          = r_count + CW'(1);
                            n_offset         = r_bump[OFFS_W-1:0];
                            n_bump           = r_bump + r_req;
                            n_free           = sub_sat(r_free, r_req);
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_out_vld;
    assign o_status       = r_status;
    assign o_block_offset = r_offset;
    assign o_reused       = r_reused;
    assign o_free_bytes   = r_free;

endmodule
`default_nettype wire

// ===== rtl/ffpa_ram.sv =====
`default_nettype none
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== tb/first_fit_pool_allocator_tb.sv =====
`timescale 1ns / 1ps

module first_fit_pool_allocator_tb;
    import ffpa_pkg::*;

    localparam int CYCLE_LIMIT = 700000;
    localparam int PHASE_ITEMS = 105;

    typedef struct {
        t_status           status;
        logic [OFFS_W-1:0] offset;
        logic              reused;
        logic [SIZE_W-1:0] free;
    } t_alloc_reply;

    class t_pool_ledger;
        logic [OFFS_W-1:0] rec_offset [MAX_RECORDS_DEF];
        logic [SIZE_W-1:0] rec_size [MAX_RECORDS_DEF];
        bit                rec_busy [MAX_RECORDS_DEF];
        int unsigned       rec_count;
        logic [SIZE_W-1:0] bump;
        logic [SIZE_W-1:0] free;
        logic [SIZE_W-1:0] pool;
        t_alloc_reply      replies_due [$];
        int unsigned       faults;

        function new();
            pool = POOL_RST;
            faults = 0;
            empty_table();
        endfunction

        function void empty_table();
            foreach (rec_busy[i]) rec_busy[i] = 1'b0;
            rec_count = 0;
            bump = '0;
            free = pool;
        endfunction

        function void set_pool(logic [SIZE_W-1:0] v);
            pool = (v > SIZE_W'(POOL_BYTES_MAX)) ? SIZE_W'(POOL_BYTES_MAX) : v;
        endfunction

        function int unsigned outstanding();
            return replies_due.size();
        endfunction

        function void note_request(t_action act, logic [SIZE_W-1:0] req,
                                   logic [OFFS_W-1:0] roff);
            t_alloc_reply      r;
            bit                hit;
            logic [SIZE_W-1:0] room;
            logic [SIZE_W:0]   sum;
            r.status = ST_DONE;
            r.offset = '0;
            r.reused = 1'b0;
            hit = 1'b0;
            case (act)
                ACT_ALLOC: begin
                    for (int i = 0; i < rec_count && !hit; i++) begin
                        if (!rec_busy[i] && rec_size[i] >= req) begin
                            rec_busy[i] = 1'b1;
                            free = (free > rec_size[i]) ? free - rec_size[i] : '0;
                            r.offset = rec_offset[i];
                            r.reused = 1'b1;
                            hit = 1'b1;
                        end
                    end
                    if (!hit) begin
                        room = (pool > bump) ? pool - bump : '0;
                        if (req > room || bump > SIZE_W'({OFFS_W{1'b1}})) begin
                            r.status = ST_POOL_FULL;
                        end else if (rec_count >= MAX_RECORDS_DEF) begin
                            r.status = ST_TABLE_FULL;
                        end else begin
                            rec_offset[rec_count] = bump[OFFS_W-1:0];
                            rec_size[rec_count] = req;
                            rec_busy[rec_count] = 1'b1;
                            rec_count++;
                            r.offset = bump[OFFS_W-1:0];
                            bump = bump + req;
                            free = (free > req) ? free - req : '0;
                        end
                    end
                end
                ACT_RELEASE: begin
                    r.status = ST_NOT_FOUND;
                    for (int i = 0; i < rec_count && !hit; i++) begin
                        if (rec_busy[i] && rec_offset[i] == roff) begin
                            rec_busy[i] = 1'b0;
                            sum = {1'b0, free} + {1'b0, rec_size[i]};
                            free = sum[SIZE_W] ? {SIZE_W{1'b1}} : sum[SIZE_W-1:0];
                            r.status = ST_DONE;
                            hit = 1'b1;
                        end
                    end
                end
                ACT_CLEAR: empty_table();
                default: ;
            endcase
            r.free = free;
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [1:0] st, logic [OFFS_W-1:0] off, logic re,
                                  logic [SIZE_W-1:0] fb);
            t_alloc_reply r;
            if (replies_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result beat: status %0d offset %0h free %0d",
                             st, off, fb);
                return;
            end
            r = replies_due.pop_front();
            if (st !== r.status || off !== r.offset || re !== r.reused || fb !== r.free) begin
                faults++;
                if (faults <= 10) begin
                    $write("mismatch (expected/actual): status %s/%0d offset %0h/%0h",
                           r.status.name(), st, r.offset, off);
                    $display(" reused %0b/%0b free %0d/%0d", r.reused, re, r.free, fb);
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [SIZE_W-1:0]   i_cfg_data;
    logic                start;
    logic                busy;
    logic [1:0]          i_action;
    logic [SIZE_W-1:0]   i_request_size;
    logic [OFFS_W-1:0]   i_release_offset;
    logic                o_done;
    logic [1:0]          o_status;
    logic [OFFS_W-1:0]   o_block_offset;
    logic                o_reused;
    logic [SIZE_W-1:0]   o_free_bytes;

    t_pool_ledger ledger;
    int unsigned  cycle_count = 0;
    int unsigned  burst_left = 0;

    first_fit_pool_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_request_size   (i_request_size),
        .i_release_offset (i_release_offset),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_block_offset   (o_block_offset),
        .o_reused         (o_reused),
        .o_free_bytes     (o_free_bytes)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_done)
            ledger.check_reply(o_status, o_block_offset, o_reused, o_free_bytes);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("first_fit_pool_allocator_tb: done, errors");
        $finish;
    end

    task automatic send_beat(t_action act, logic [SIZE_W-1:0] req,
                             logic [OFFS_W-1:0] roff);
        start <= 1'b1;
        i_action <= act;
        i_request_size <= req;
        i_release_offset <= roff;
        do @(posedge i_clk); while (busy);
        ledger.note_request(act, req, roff);
    endtask

    task automatic pace();
        int unsigned gap;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_pool(logic [SIZE_W-1:0] v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.set_pool(v);
    endtask

    task automatic random_item(int unsigned release_share, output bit counted);
        int unsigned       pick;
        int unsigned       choice;
        logic [SIZE_W-1:0] req;
        logic [SIZE_W-1:0] p;
        logic [OFFS_W-1:0] roff;
        t_action           act;
        p = ledger.pool;
        req = SIZE_W'($urandom_range(0, 17'h1FFFF));
        roff = OFFS_W'($urandom_range(0, 16'hFFFF));
        pick = $urandom_range(0, 999);
        choice = $urandom_range(0, 19);
        counted = 1'b1;
        if (pick < 985 - release_share) begin
            act = ACT_ALLOC;
            if (choice < 12)
                req = SIZE_W'($urandom_range(0, p / 48 + 2));
            else if (choice < 15 && ledger.rec_count != 0)
                req = ledger.rec_size[$urandom_range(0, ledger.rec_count - 1)];
            else if (choice < 17)
                req = SIZE_W'($urandom_range(0, p));
            else if (choice == 17)
                req = '0;
        end else if (pick < 985) begin
            act = ACT_RELEASE;
            if (choice < 14 && ledger.rec_count != 0)
                roff = ledger.rec_offset[$urandom_range(0, ledger.rec_count - 1)];
            else if (choice < 16)
                roff = ledger.bump[OFFS_W-1:0];
        end else if (pick < 990) begin
            act = ACT_CLEAR;
        end else begin
            act = ACT_NONE;
            counted = 1'b0;
        end
        send_beat(act, req, roff);
        pace();
    endtask

    initial begin
        logic [SIZE_W-1:0] pool_plan [8];
        int unsigned       done_items;
        bit                counted;
        ledger = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        start <= 1'b0;
        i_action <= ACT_NONE;
        i_request_size <= '0;
        i_release_offset <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(ACT_NONE, 17'h1FFFF, 16'hFFFF);
        send_beat(ACT_RELEASE, 17'h1FFFF, 16'h0000);
        send_beat(ACT_ALLOC, 17'd0, 16'hFFFF);
        pace();
        send_beat(ACT_ALLOC, 17'd100, 16'h0000);
        send_beat(ACT_ALLOC, 17'h1FFFF, 16'h0000);
        send_beat(ACT_RELEASE, 17'd0, 16'h0000);
        send_beat(ACT_RELEASE, 17'd0, 16'h0000);
        pace();
        send_beat(ACT_RELEASE, 17'd0, 16'h0000);
        send_beat(ACT_ALLOC, 17'd50, 16'h0000);
        send_beat(ACT_ALLOC, 17'd0, 16'h0000);
        send_beat(ACT_ALLOC, 17'd65436, 16'h0000);
        send_beat(ACT_ALLOC, 17'd0, 16'h0000);
        pace();
        send_beat(ACT_RELEASE, 17'd0, 16'd100);
        send_beat(ACT_RELEASE, 17'd0, 16'hFFFF);
        send_beat(ACT_CLEAR, 17'h1FFFF, 16'hFFFF);
        send_beat(ACT_ALLOC, 17'd65536, 16'h0000);
        send_beat(ACT_ALLOC, 17'd1, 16'h0000);
        send_beat(ACT_ALLOC, 17'd65537, 16'h0000);
        send_beat(ACT_CLEAR, 17'd0, 16'h0000);

        pool_plan[0] = 17'h1FFFF;
        pool_plan[1] = 17'd1;
        pool_plan[2] = 17'd0;
        pool_plan[3] = 17'd300;
        pool_plan[4] = 17'd4096;
        pool_plan[5] = 17'd65536;
        pool_plan[6] = SIZE_W'($urandom_range(2, 65535));
        pool_plan[7] = 17'd1000;
        foreach (pool_plan[k]) begin
            write_pool(pool_plan[k]);
            send_beat(ACT_CLEAR, SIZE_W'($urandom_range(0, 17'h1FFFF)),
                      OFFS_W'($urandom_range(0, 16'hFFFF)));
            pace();
            done_items = 1;
            while (done_items < PHASE_ITEMS) begin
                random_item((k % 2 == 0) ? 350 : 80, counted);
                if (counted) done_items++;
                if ($urandom_range(0, 119) == 0) settle();
            end
        end

        settle();
        repeat (MAX_RECORDS_DEF + 4) @(posedge i_clk);
        if (ledger.faults == 0 && ledger.outstanding() == 0)
            $display("first_fit_pool_allocator_tb: done, clean");
        else
            $display("first_fit_pool_allocator_tb: done, errors");
        $finish;
    end

endmodule

// ===== first_fit_pool_allocator.f =====
rtl/ffpa_pkg.sv
rtl/ffpa_ram.sv
rtl/first_fit_pool_allocator.sv
tb/first_fit_pool_allocator_tb.sv
